[rtl/core/luminance_tone_mapper_top_macros.svh]
// Assertion macros for the tone mapper RTL (used by ltm_queue).
`ifndef LUMINANCE_TONE_MAPPER_TOP_MACROS_SVH
`define LUMINANCE_TONE_MAPPER_TOP_MACROS_SVH
`ifndef SYNTH
`define LTM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define LTM_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("check failed");
`else
`define LTM_ASSERT(lbl, clk, rstn, prop)
`define LTM_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[rtl/core/ltm_pkg.sv]
`default_nettype none
package ltm_pkg;
  localparam int unsigned ChanW = 24;
  localparam int unsigned LumaW = 25;
  localparam logic [LumaW-1:0] LumaMax = '1;
  localparam logic [23:0] WeightR =
    24'(((64'd2126 << 32) + 64'd1275000) / 64'd2550000);
  localparam logic [23:0] WeightG =
    24'(((64'd7152 << 32) + 64'd1275000) / 64'd2550000);
  localparam logic [23:0] WeightB =
    24'(((64'd722 << 32) + 64'd1275000) / 64'd2550000);
  localparam int unsigned GainFrac = 24;
  // gain is always below 1.0, so its fraction bits hold all of it
  localparam int unsigned GainW = 24;
  localparam int unsigned DivW = 64;
  localparam int unsigned DenW = 26;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [LumaW-1:0] luma;
    logic [LumaW-1:0] max_luma;
    logic             bypass;
    logic             recompute;
  } ltm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ltm_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_INV1, BK_INV2, BK_NUM, BK_GSTART, BK_GAIN, BK_SCALE, BK_OUT
  } ltm_bk_state_e;
endpackage
`default_nettype wire

[rtl/core/luminance_tone_mapper_top.sv]
// Luminance tone mapper (extended Reinhard on luminance).
// Input channel: in_valid_i / in_stall_o with kind, first and 16.8 RGB.
// Send each frame twice: measure pixels (kind 0) update the frame maximum
// and give no result; map pixels (kind 1) give one result each, in order.
// Output channel: out_valid_o / out_stall_i; the result holds while stalled.
// The front takes one item per cycle unless a map item waits on a full
// queue, computes luminance and queues map items four deep; measure items
// never wait on the back end. In the back end a bypassed pixel goes from
// the queue straight to the output; a mapped pixel runs its gain divide on
// a bit-serial divider, then scales the three channels one at a time; the
// first mapped pixel after measure pixels also recomputes 1/max^2 with the
// same divider. Sustained map-pass rate is set by that shared divider.
// Reset clears the maximum to zero, so map pixels pass unchanged until a
// measure pass raises it above 1.0. A stalled output backs up the queue and
// then the input.
`default_nettype none
module luminance_tone_mapper_top import ltm_pkg::*; #(
  parameter int unsigned CHANNEL_FRAC_BITS = 8,
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             kind_i,
  input  wire logic             first_i,
  input  wire logic [ChanW-1:0] red_in_i,
  input  wire logic [ChanW-1:0] green_in_i,
  input  wire logic [ChanW-1:0] blue_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ChanW-1:0]      red_out_o,
  output logic [ChanW-1:0]      green_out_o,
  output logic [ChanW-1:0]      blue_out_o,
  output logic                  bypassed_o
);
  ltm_qstat_t qstat;
  ltm_item_t  push_item, head_item;
  logic       push, pop;

  ltm_front #(.CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS), .LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .first_i,
    .red_in_i, .green_in_i, .blue_in_i, .qstat_i(qstat), .push_o(push), .item_o(push_item)
  );

  ltm_queue #(.DEPTH(4)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .pop_i(pop),
    .item_o(head_item), .qstat_o(qstat)
  );

  ltm_back #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .qstat_i(qstat), .item_i(head_item), .pop_o(pop),
    .out_valid_o, .out_stall_i, .red_out_o, .green_out_o, .blue_out_o, .bypassed_o
  );
endmodule
`default_nettype wire

[rtl/core/ltm_front.sv]
`default_nettype none
module ltm_front import ltm_pkg::*; #(
  parameter int unsigned CHANNEL_FRAC_BITS = 8,
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             kind_i,
  input  wire logic             first_i,
  input  wire logic [ChanW-1:0] red_in_i,
  input  wire logic [ChanW-1:0] green_in_i,
  input  wire logic [ChanW-1:0] blue_in_i,
  input  wire ltm_qstat_t       qstat_i,
  output logic                  push_o,
  output ltm_item_t             item_o
);
  localparam int unsigned Shift = 32 + CHANNEL_FRAC_BITS - LUMA_FRAC_BITS;

  logic             valid_q, kind_q, first_q, stale_q;
  logic [ChanW-1:0] r_q, g_q, b_q;
  logic [47:0]      pr_q, pg_q, pb_q;
  logic [LumaW-1:0] max_q;
  logic [51:0]      sum_w, lv;
  logic [LumaW-1:0] luma;
  logic             move, accept, bypass;

  always_comb begin
    sum_w  = 52'(pr_q) + 52'(pg_q) + 52'(pb_q) + (52'd1 << (Shift - 1));
    lv     = sum_w >> Shift;
    luma   = (lv > 52'(LumaMax)) ? LumaMax : lv[LumaW-1:0];
    bypass = ({1'b0, max_q} <= (26'd1 << LUMA_FRAC_BITS)) || (luma == '0);
    move   = valid_q && (!kind_q || !qstat_i.full);
    accept = in_valid_i && !in_stall_o;
  end

  assign in_stall_o = valid_q && !move;
  assign push_o     = valid_q && kind_q && !qstat_i.full;
  assign item_o     = '{red: r_q, green: g_q, blue: b_q, luma: luma, max_luma: max_q,
                        bypass: bypass, recompute: stale_q && !bypass};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      max_q   <= '0;
      stale_q <= 1'b1;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
      end else if (move) begin
        valid_q <= 1'b0;
      end
      if (move && !kind_q) begin
        if (first_q || luma > max_q) begin
          max_q <= luma;
        end
        stale_q <= 1'b1;
      end else if (push_o && !bypass) begin
        stale_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      first_q <= first_i;
      r_q     <= red_in_i;
      g_q     <= green_in_i;
      b_q     <= blue_in_i;
      pr_q    <= 48'(red_in_i) * 48'(WeightR);
      pg_q    <= 48'(green_in_i) * 48'(WeightG);
      pb_q    <= 48'(blue_in_i) * 48'(WeightB);
    end
  end
endmodule
`default_nettype wire

[rtl/core/ltm_queue.sv]
`default_nettype none
`include "luminance_tone_mapper_top_macros.svh"
module ltm_queue import ltm_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ltm_item_t item_i,
  input  wire logic      pop_i,
  output ltm_item_t      item_o,
  output ltm_qstat_t     qstat_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ltm_item_t       mem_q [DEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign qstat_o.full  = (cnt_q == (AW+1)'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign item_o        = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  `LTM_NEVER(a_no_overflow, clk_i, rst_ni, push_i && qstat_o.full)
  `LTM_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && qstat_o.empty)
  `LTM_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (AW+1)'(DEPTH))
endmodule
`default_nettype wire

[rtl/core/ltm_div.sv]
`default_nettype none
module ltm_div import ltm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DenW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DivW-1:0]      quot_o
);
  // restoring divide, one quotient bit per cycle
  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [DivW-1:0] dvd_q, quot_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [DenW:0]   trial;
  logic            fits;

  always_comb begin
    trial = {rem_q, dvd_q[DivW-1]};
    fits  = trial >= {1'b0, den_q};
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      rem_q  <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quot_q <= {quot_q[DivW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

[rtl/core/ltm_back.sv]
`default_nettype none
module ltm_back import ltm_pkg::*; #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ltm_qstat_t       qstat_i,
  input  wire ltm_item_t        item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ChanW-1:0]      red_out_o,
  output logic [ChanW-1:0]      green_out_o,
  output logic [ChanW-1:0]      blue_out_o,
  output logic                  bypassed_o
);
  ltm_bk_state_e    state_q, state_d;
  ltm_item_t        it_q;
  logic [31:0]      inv_q;
  logic [26:0]      num_q;
  logic [GainW-1:0] gain_q;
  logic [1:0]       ch_q;
  logic [ChanW-1:0] ro_q, go_q, bo_q;
  logic             byp_q;
  logic             div_start, div_done;
  logic [DivW-1:0]  div_dvd, div_q;
  logic [DenW-1:0]  div_den;
  logic [ChanW-1:0] ch_sel, ch_res;
  logic [67:0]      sc;
  logic [56:0]      prod;

  ltm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          if (item_i.bypass) state_d = BK_OUT;
          else if (item_i.recompute) state_d = BK_INV1;
          else state_d = BK_NUM;
        end
      end
      BK_INV1:   if (div_done) state_d = BK_INV2;
      BK_INV2:   if (div_done) state_d = BK_NUM;
      BK_NUM:    state_d = BK_GSTART;
      BK_GSTART: state_d = BK_GAIN;
      BK_GAIN:   if (div_done) state_d = BK_SCALE;
      BK_SCALE:  if (ch_q == 2'd2) state_d = BK_OUT;
      BK_OUT:    if (!out_stall_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == BK_IDLE) && !qstat_i.empty;
    div_start = 1'b0;
    div_dvd   = '0;
    div_den   = DenW'(it_q.max_luma);
    case (state_q)
      BK_IDLE: begin
        div_start = pop_o && !item_i.bypass && item_i.recompute;
        div_dvd   = DivW'(1) << (32 + LUMA_FRAC_BITS);
        div_den   = DenW'(item_i.max_luma);
      end
      BK_INV1: begin
        div_start = div_done;
        div_dvd   = div_q << LUMA_FRAC_BITS;
      end
      BK_GSTART: begin
        div_start = 1'b1;
        div_dvd   = DivW'(num_q) << GainFrac;
        div_den   = DenW'((DenW'(1) << LUMA_FRAC_BITS) + DenW'(it_q.luma));
      end
      default: ;
    endcase
    out_valid_o = (state_q == BK_OUT);
    prod   = 57'(it_q.luma) * 57'(inv_q);
    ch_sel = (ch_q == 2'd0) ? it_q.red : (ch_q == 2'd1) ? it_q.green : it_q.blue;
    sc     = (68'(ch_sel) * 68'(gain_q) + (68'd1 << (GainFrac - 1))) >> GainFrac;
    ch_res = (sc > 68'(24'hFFFFFF)) ? 24'hFFFFFF : sc[ChanW-1:0];
  end

  assign red_out_o   = ro_q;
  assign green_out_o = go_q;
  assign blue_out_o  = bo_q;
  assign bypassed_o  = byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q  <= item_i;
      ro_q  <= item_i.red;
      go_q  <= item_i.green;
      bo_q  <= item_i.blue;
      byp_q <= item_i.bypass;
    end
    if (state_q == BK_INV2 && div_done) inv_q <= div_q[31:0];
    if (state_q == BK_NUM) num_q <= 27'((27'd1 << LUMA_FRAC_BITS) + 27'(prod >> 32));
    if (state_q == BK_GAIN && div_done) begin
      gain_q <= div_q[GainW-1:0];
      ch_q   <= 2'd0;
    end
    if (state_q == BK_SCALE) begin
      ch_q <= ch_q + 1'b1;
      case (ch_q)
        2'd0:    ro_q <= ch_res;
        2'd1:    go_q <= ch_res;
        default: bo_q <= ch_res;
      endcase
    end
  end
endmodule
`default_nettype wire
